[rtl/core/keyword_substitution_cipher_assert.svh]
// assertion macros for the keyword substitution cipher
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define KSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksc assertion failed");

// next-cycle implication, disabled while reset is held
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksc assertion failed");

`endif

[rtl/core/ksc_pkg.sv]
`default_nettype none

package ksc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int ALPHA_W       = 5;
    localparam int KEY_LIMIT_DEF = 26;

    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ENC    = 2'd2,
        KIND_DEC    = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic               key_step;
        logic               text_step;
        logic               decrypt;
        logic               fill_step;
        logic               fill_last;
        logic [ALPHA_W-1:0] fill_idx;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic table_full;
    } t_dp_status;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ksc_dp.sv]
`default_nettype none

module ksc_dp #(
    parameter int KEY_LIMIT = ksc_pkg::KEY_LIMIT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ksc_pkg::t_dp_cmd    i_cmd,
    input  wire logic [7:0]          i_char,
    output ksc_pkg::t_dp_status      o_status,
    output logic [7:0]               o_char
);

    localparam int RAW_W = $clog2(KEY_LIMIT + 1);
    localparam int AW    = ksc_pkg::ALPHA_W;
    localparam int AS    = ksc_pkg::ALPHABET_SIZE;

    // key tables, written once per plain letter before the key is ready
    logic [AW-1:0] r_fwd [AS];
    logic [AW-1:0] r_inv [AS];

    logic [AS-1:0]    r_used, n_used;
    logic [AW-1:0]    r_filled, n_filled;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic             r_ready, n_ready;
    logic [7:0]       r_char;

    logic [7:0]       w_lower;
    logic             w_is_letter;
    logic [AW-1:0]    w_letter;
    logic [AS-1:0]    w_eff_used;
    logic [AW-1:0]    w_eff_filled;
    logic [RAW_W-1:0] w_eff_raw;
    logic             w_assign;
    logic [AW-1:0]    w_assign_pos;
    logic [AW-1:0]    w_assign_letter;
    logic [AW-1:0]    w_sub;
    logic [7:0]       w_text_out;

    assign w_lower     = ksc_pkg::to_lower(i_char);
    assign w_is_letter = (w_lower >= ksc_pkg::LOWER_A) && (w_lower <= ksc_pkg::LOWER_Z);
    assign w_letter    = AW'(w_lower - ksc_pkg::LOWER_A);

    // a key character after a finished key starts over
    assign w_eff_used   = r_ready ? '0 : r_used;
    assign w_eff_filled = r_ready ? '0 : r_filled;
    assign w_eff_raw    = r_ready ? '0 : r_raw;

    always_comb begin
        n_used          = r_used;
        n_filled        = r_filled;
        n_raw           = r_raw;
        n_ready         = r_ready;
        w_assign        = 1'b0;
        w_assign_pos    = r_filled;
        w_assign_letter = w_letter;
        if (i_cmd.key_step) begin
            n_ready      = 1'b0;
            n_used       = w_eff_used;
            n_filled     = w_eff_filled;
            n_raw        = w_eff_raw;
            w_assign_pos = w_eff_filled;
            if (w_eff_raw < RAW_W'(KEY_LIMIT)) begin
                n_raw = w_eff_raw + 1'b1;
                if (w_is_letter && !w_eff_used[w_letter] && w_eff_filled < AW'(AS)) begin
                    w_assign           = 1'b1;
                    n_used[w_letter]   = 1'b1;
                    n_filled           = w_eff_filled + 1'b1;
                end
            end
        end else if (i_cmd.fill_step) begin
            w_assign_letter = i_cmd.fill_idx;
            if (r_filled < AW'(AS) && !r_used[i_cmd.fill_idx]) begin
                w_assign                 = 1'b1;
                n_used[i_cmd.fill_idx]   = 1'b1;
                n_filled                 = r_filled + 1'b1;
            end
            if (i_cmd.fill_last) begin
                n_ready = 1'b1;
            end
        end
    end

    assign w_sub      = i_cmd.decrypt ? r_inv[w_letter] : r_fwd[w_letter];
    assign w_text_out = (r_ready && w_is_letter) ? (ksc_pkg::LOWER_A + 8'(w_sub)) : w_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_filled <= '0;
            r_raw    <= '0;
            r_ready  <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_filled <= n_filled;
            r_raw    <= n_raw;
            r_ready  <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_assign) begin
            r_fwd[w_assign_pos]    <= w_assign_letter;
            r_inv[w_assign_letter] <= w_assign_pos;
        end
        if (i_cmd.text_step) begin
            r_char <= w_text_out;
        end
    end

    assign o_status.table_full = (r_filled == AW'(AS));
    assign o_char              = r_char;

endmodule

`default_nettype wire

[rtl/core/ksc_ctrl.sv]
`default_nettype none

module ksc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_valid,
    input  wire logic [1:0]           i_kind,
    output logic                      o_s_ready,
    output logic                      o_m_valid,
    input  wire logic                 i_m_ready,
    input  wire ksc_pkg::t_dp_status  i_status,
    output ksc_pkg::t_dp_cmd          o_cmd
);

    localparam int AW = ksc_pkg::ALPHA_W;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_fill_idx, n_fill_idx;
    logic          r_out_valid, n_out_valid;

    logic          w_accept;
    ksc_pkg::t_kind w_kind;

    assign w_kind    = ksc_pkg::t_kind'(i_kind);
    assign o_s_ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_ready);
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.fill_idx  = r_fill_idx;
        o_cmd.decrypt   = (w_kind == ksc_pkg::KIND_DEC);
        n_state         = r_state;
        n_fill_idx      = r_fill_idx;
        n_out_valid     = r_out_valid && !i_m_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_kind)
                        ksc_pkg::KIND_KEY: begin
                            o_cmd.key_step = 1'b1;
                        end
                        ksc_pkg::KIND_FINISH: begin
                            n_state    = ST_FILL;
                            n_fill_idx = '0;
                        end
                        default: begin
                            o_cmd.text_step = 1'b1;
                            n_out_valid     = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                // stop early once every plain letter has an image
                if (i_status.table_full ||
                    r_fill_idx == AW'(ksc_pkg::ALPHABET_SIZE - 1)) begin
                    o_cmd.fill_last = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_fill_idx = r_fill_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_idx  <= n_fill_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/keyword_substitution_cipher.sv]
// keyword substitution cipher
// slave stream s_axis_*: one word per item, tuser holds the kind (key character,
// finish key, encrypt, decrypt) and tdata holds the raw byte
// master stream m_axis_*: one word for every encrypt or decrypt item, none for
// key or finish items; tdata holds the substituted lowercase byte
// key characters and text items are taken back to back unless m_axis stalls; a text result appears on
// m_axis in the cycle after it is accepted and sits in an output register, so the
// next item is taken in the same cycle that the result is taken downstream
// a finish item walks the alphabet one letter per cycle to fill the unused
// letters, so it holds tready low after it is accepted until the walk ends
// (sooner when the key already covers the whole alphabet)
// while m_axis is stalled with a result waiting, s_axis_tready stays low
// reset (i_rst_n low, synchronous) clears the key state: text passes through
// lowercased until a key is finished; the tables themselves are not cleared
// only the first KEY_LIMIT raw key characters of a key count
`default_nettype none

`include "keyword_substitution_cipher_assert.svh"

module keyword_substitution_cipher #(
    parameter int KEY_LIMIT = ksc_pkg::KEY_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] char_out
);

    ksc_pkg::t_dp_cmd    w_cmd;
    ksc_pkg::t_dp_status w_status;

    // handshake terms used by the checks below
    logic w_s_fire;
    logic w_s_text;
    logic w_m_wait;

    // sequencing: accepts words, walks the fill on finish, owns output valid
    ksc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // key state, forward and inverse tables, output byte register
    ksc_dp #(
        .KEY_LIMIT (KEY_LIMIT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_char   (s_axis_tdata),
        .o_status (w_status),
        .o_char   (m_axis_tdata)
    );

    assign w_s_fire = s_axis_tvalid && s_axis_tready;
    assign w_s_text = (s_axis_tuser == ksc_pkg::KIND_ENC) ||
                      (s_axis_tuser == ksc_pkg::KIND_DEC);
    assign w_m_wait = m_axis_tvalid && !m_axis_tready;

    // a waiting result that is not taken blocks new input
    `KSC_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, w_m_wait, !s_axis_tready)

    // no input is taken while the fill walk runs
    `KSC_ASSERT_NOW(a_fill_blocks_input, i_clk, i_rst_n, w_cmd.fill_step, !s_axis_tready)

    // an accepted text word gives a result in the next cycle
    `KSC_ASSERT_NEXT(a_text_gives_result, i_clk, i_rst_n, w_s_fire && w_s_text, m_axis_tvalid)

    // key and finish words never raise a result
    `KSC_ASSERT_NEXT(a_key_no_result, i_clk, i_rst_n, w_s_fire && !w_s_text, !$rose(m_axis_tvalid))

endmodule

`default_nettype wire
